/* rtl/core/ruf_pkg.sv */
package ruf_pkg;

  localparam int NODES     = 1024;
  localparam int NW        = $clog2(NODES);
  localparam int SW        = $clog2(NODES) + 1;
  localparam int LOG_DEPTH = 2 * (NODES - 1);
  localparam int LW        = $clog2(LOG_DEPTH);
  localparam int CW        = $clog2(LOG_DEPTH + 1);

  typedef logic [1:0]    opcode_t;
  typedef logic [NW-1:0] node_t;
  typedef logic [SW-1:0] size_t;
  typedef logic [LW-1:0] log_idx_t;
  typedef logic [CW-1:0] log_cnt_t;

  localparam opcode_t OP_MERGE    = 2'd0;
  localparam opcode_t OP_ROLLBACK = 2'd1;
  localparam opcode_t OP_QUERY    = 2'd2;

  typedef struct packed {
    logic  is_size;
    node_t index;
    size_t value;
  } undo_rec_t;

  typedef struct packed {
    logic  par_we;
    node_t par_addr;
    node_t par_data;
    logic  size_we;
    node_t size_addr;
    size_t size_data;
  } tbl_wr_t;

  typedef struct packed {
    logic      we;
    log_idx_t  addr;
    undo_rec_t data;
  } log_wr_t;

endpackage

/* rtl/core/ruf_in_if.sv */
interface ruf_in_if;
  logic                valid;
  logic                ready;
  ruf_pkg::opcode_t    opcode;
  ruf_pkg::node_t      node_a;
  ruf_pkg::node_t      node_b;
  logic [10:0]         rollback_mark;

  modport source (output valid, output opcode, output node_a, output node_b,
                  output rollback_mark, input ready);
  modport sink (input valid, input opcode, input node_a, input node_b,
                input rollback_mark, output ready);
endinterface

/* rtl/core/ruf_out_if.sv */
interface ruf_out_if;
  logic                valid;
  logic                ready;
  ruf_pkg::node_t      root_a;
  ruf_pkg::size_t      set_size_a;
  ruf_pkg::node_t      root_b;
  ruf_pkg::size_t      set_size_b;
  logic                merged;
  ruf_pkg::log_cnt_t   log_length;

  modport source (output valid, output root_a, output set_size_a, output root_b,
                  output set_size_b, output merged, output log_length, input ready);
  modport sink (input valid, input root_a, input set_size_a, input root_b,
                input set_size_b, input merged, input log_length, output ready);
endinterface

/* rtl/core/ruf_node_table.sv */
module ruf_node_table (
  input  logic              clk,
  input  ruf_pkg::node_t    rd_addr,
  output ruf_pkg::node_t    rd_parent,
  output ruf_pkg::size_t    rd_size,
  input  ruf_pkg::tbl_wr_t  wr
);

  ruf_pkg::node_t parent_mem [ruf_pkg::NODES];
  ruf_pkg::size_t size_mem [ruf_pkg::NODES];
  ruf_pkg::node_t rd_parent_r;
  ruf_pkg::size_t rd_size_r;

  always_ff @(posedge clk) begin
    if (wr.par_we) begin
      parent_mem[wr.par_addr] <= wr.par_data;
    end
    if (wr.size_we) begin
      size_mem[wr.size_addr] <= wr.size_data;
    end
    rd_parent_r <= parent_mem[rd_addr];
    rd_size_r   <= size_mem[rd_addr];
  end

  assign rd_parent = rd_parent_r;
  assign rd_size   = rd_size_r;

endmodule

/* rtl/core/ruf_undo_log.sv */
module ruf_undo_log (
  input  logic                clk,
  input  ruf_pkg::log_wr_t    wr,
  input  ruf_pkg::log_idx_t   rd_addr,
  output ruf_pkg::undo_rec_t  rd_data
);

  ruf_pkg::undo_rec_t log_mem [ruf_pkg::LOG_DEPTH];
  ruf_pkg::undo_rec_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      log_mem[wr.addr] <= wr.data;
    end
    rd_data_r <= log_mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/core/rollback_union_find_unit.sv */
// Channel  Dir  Handshake      Payload
// in_ch    in   valid / ready  opcode, node_a, node_b, rollback_mark
// out_ch   out  valid / ready  root_a, set_size_a, root_b, set_size_b, merged, log_length
//
// After reset the unit writes every entry of the parent and size tables, with
// in_ch.ready low. A query walks the parent links from node_a, then from node_b,
// to their roots, one link per cycle. A merge that joins two sets then updates
// the tables and logs undo records; a rollback first undoes records to its mark.
// One transaction is in work at a time; a finished result that finds out_ch still
// occupied waits until the previous one is taken.
module rollback_union_find_unit (
  input logic      clk,
  input logic      rst_n,
  ruf_in_if.sink   in_ch,
  ruf_out_if.source out_ch
);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_RB, ST_FA0, ST_FA, ST_FB0, ST_FB, ST_MW1, ST_MW2, ST_FIN
  } state_t;

  state_t              state_r, state_nxt;
  ruf_pkg::node_t      clr_r, clr_nxt;
  ruf_pkg::opcode_t    op_r, op_nxt;
  ruf_pkg::node_t      a_r, a_nxt;
  ruf_pkg::node_t      b_r, b_nxt;
  ruf_pkg::log_cnt_t   mark_r, mark_nxt;
  ruf_pkg::node_t      x_r, x_nxt;
  ruf_pkg::node_t      ra_r, ra_nxt;
  ruf_pkg::node_t      rb_r, rb_nxt;
  ruf_pkg::size_t      sa_r, sa_nxt;
  ruf_pkg::size_t      sb_r, sb_nxt;
  ruf_pkg::size_t      old_r, old_nxt;
  logic                merged_r, merged_nxt;
  ruf_pkg::log_cnt_t   cnt_r, cnt_nxt;
  logic                pend_r, pend_nxt;
  logic                out_valid_r, out_valid_nxt;
  ruf_pkg::node_t      o_ra_r, o_ra_nxt;
  ruf_pkg::node_t      o_rb_r, o_rb_nxt;
  ruf_pkg::size_t      o_sa_r, o_sa_nxt;
  ruf_pkg::size_t      o_sb_r, o_sb_nxt;
  logic                o_merged_r, o_merged_nxt;
  ruf_pkg::log_cnt_t   o_len_r, o_len_nxt;

  ruf_pkg::node_t      tbl_rd_addr;
  ruf_pkg::node_t      tbl_rd_parent;
  ruf_pkg::size_t      tbl_rd_size;
  ruf_pkg::tbl_wr_t    tbl_wr;
  ruf_pkg::log_wr_t    log_wr;
  ruf_pkg::log_idx_t   log_rd_addr;
  ruf_pkg::undo_rec_t  log_rd_data;
  ruf_pkg::log_cnt_t   cnt_dec;
  logic                swap;
  ruf_pkg::node_t      lo_root;
  ruf_pkg::node_t      hi_root;
  ruf_pkg::size_t      sum_size;

  ruf_node_table u_table (
    .clk       (clk),
    .rd_addr   (tbl_rd_addr),
    .rd_parent (tbl_rd_parent),
    .rd_size   (tbl_rd_size),
    .wr        (tbl_wr)
  );

  ruf_undo_log u_log (
    .clk     (clk),
    .wr      (log_wr),
    .rd_addr (log_rd_addr),
    .rd_data (log_rd_data)
  );

  assign in_ch.ready       = (state_r == ST_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.root_a     = o_ra_r;
  assign out_ch.set_size_a = o_sa_r;
  assign out_ch.root_b     = o_rb_r;
  assign out_ch.set_size_b = o_sb_r;
  assign out_ch.merged     = o_merged_r;
  assign out_ch.log_length = o_len_r;

  assign cnt_dec     = cnt_r - 1'b1;
  assign log_rd_addr = cnt_dec[ruf_pkg::LW-1:0];
  assign swap        = (sa_r > sb_r);
  assign lo_root     = swap ? rb_r : ra_r;
  assign hi_root     = swap ? ra_r : rb_r;
  assign sum_size    = sa_r + sb_r;

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    op_nxt        = op_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    mark_nxt      = mark_r;
    x_nxt         = x_r;
    ra_nxt        = ra_r;
    rb_nxt        = rb_r;
    sa_nxt        = sa_r;
    sb_nxt        = sb_r;
    old_nxt       = old_r;
    merged_nxt    = merged_r;
    cnt_nxt       = cnt_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r;
    o_ra_nxt      = o_ra_r;
    o_rb_nxt      = o_rb_r;
    o_sa_nxt      = o_sa_r;
    o_sb_nxt      = o_sb_r;
    o_merged_nxt  = o_merged_r;
    o_len_nxt     = o_len_r;
    tbl_rd_addr   = x_r;
    tbl_wr        = '0;
    log_wr        = '0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        tbl_wr.par_we    = 1'b1;
        tbl_wr.par_addr  = clr_r;
        tbl_wr.par_data  = clr_r;
        tbl_wr.size_we   = 1'b1;
        tbl_wr.size_addr = clr_r;
        tbl_wr.size_data = ruf_pkg::size_t'(1);
        clr_nxt          = clr_r + 1'b1;
        if (clr_r == ruf_pkg::node_t'(ruf_pkg::NODES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_ch.valid) begin
          op_nxt     = in_ch.opcode;
          a_nxt      = in_ch.node_a;
          b_nxt      = in_ch.node_b;
          mark_nxt   = in_ch.rollback_mark;
          merged_nxt = 1'b0;
          pend_nxt   = 1'b0;
          state_nxt  = (in_ch.opcode == ruf_pkg::OP_ROLLBACK) ? ST_RB : ST_FA0;
        end
      end
      ST_RB: begin
        if (pend_r) begin
          if (log_rd_data.is_size) begin
            tbl_wr.size_we   = 1'b1;
            tbl_wr.size_addr = log_rd_data.index;
            tbl_wr.size_data = log_rd_data.value;
          end else begin
            tbl_wr.par_we   = 1'b1;
            tbl_wr.par_addr = log_rd_data.index;
            tbl_wr.par_data = log_rd_data.value[ruf_pkg::NW-1:0];
          end
        end
        if (cnt_r > mark_r) begin
          cnt_nxt  = cnt_dec;
          pend_nxt = 1'b1;
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = ST_FA0;
        end
      end
      ST_FA0: begin
        tbl_rd_addr = a_r;
        x_nxt       = a_r;
        state_nxt   = ST_FA;
      end
      ST_FA: begin
        tbl_rd_addr = tbl_rd_parent;
        if (tbl_rd_parent == x_r) begin
          ra_nxt    = x_r;
          sa_nxt    = tbl_rd_size;
          state_nxt = ST_FB0;
        end else begin
          x_nxt = tbl_rd_parent;
        end
      end
      ST_FB0: begin
        tbl_rd_addr = b_r;
        x_nxt       = b_r;
        state_nxt   = ST_FB;
      end
      ST_FB: begin
        tbl_rd_addr = tbl_rd_parent;
        if (tbl_rd_parent == x_r) begin
          rb_nxt = x_r;
          sb_nxt = tbl_rd_size;
          if ((op_r == ruf_pkg::OP_MERGE) && (x_r != ra_r)) begin
            state_nxt = ST_MW1;
          end else begin
            state_nxt = ST_FIN;
          end
        end else begin
          x_nxt = tbl_rd_parent;
        end
      end
      ST_MW1: begin
        tbl_wr.par_we    = 1'b1;
        tbl_wr.par_addr  = lo_root;
        tbl_wr.par_data  = hi_root;
        tbl_wr.size_we   = 1'b1;
        tbl_wr.size_addr = hi_root;
        tbl_wr.size_data = sum_size;
        if (cnt_r < ruf_pkg::log_cnt_t'(ruf_pkg::LOG_DEPTH)) begin
          log_wr.we           = 1'b1;
          log_wr.addr         = cnt_r[ruf_pkg::LW-1:0];
          log_wr.data.is_size = 1'b0;
          log_wr.data.index   = lo_root;
          log_wr.data.value   = ruf_pkg::size_t'(lo_root);
          cnt_nxt             = cnt_r + 1'b1;
        end
        old_nxt    = swap ? sa_r : sb_r;
        ra_nxt     = hi_root;
        rb_nxt     = hi_root;
        sa_nxt     = sum_size;
        sb_nxt     = sum_size;
        merged_nxt = 1'b1;
        state_nxt  = ST_MW2;
      end
      ST_MW2: begin
        if (cnt_r < ruf_pkg::log_cnt_t'(ruf_pkg::LOG_DEPTH)) begin
          log_wr.we           = 1'b1;
          log_wr.addr         = cnt_r[ruf_pkg::LW-1:0];
          log_wr.data.is_size = 1'b1;
          log_wr.data.index   = ra_r;
          log_wr.data.value   = old_r;
          cnt_nxt             = cnt_r + 1'b1;
        end
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          o_ra_nxt      = ra_r;
          o_rb_nxt      = rb_r;
          o_sa_nxt      = sa_r;
          o_sb_nxt      = sb_r;
          o_merged_nxt  = merged_r;
          o_len_nxt     = cnt_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    mark_r     <= mark_nxt;
    x_r        <= x_nxt;
    ra_r       <= ra_nxt;
    rb_r       <= rb_nxt;
    sa_r       <= sa_nxt;
    sb_r       <= sb_nxt;
    old_r      <= old_nxt;
    merged_r   <= merged_nxt;
    o_ra_r     <= o_ra_nxt;
    o_rb_r     <= o_rb_nxt;
    o_sa_r     <= o_sa_nxt;
    o_sb_r     <= o_sb_nxt;
    o_merged_r <= o_merged_nxt;
    o_len_r    <= o_len_nxt;
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // The undo log never holds more records than it has entries.
  a_log_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= ruf_pkg::log_cnt_t'(ruf_pkg::LOG_DEPTH))
    else $error("undo log count above its depth");

  // A rollback never pops below its mark.
  a_rb_mark: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RB && cnt_r > mark_r) |=> (cnt_r >= mark_r))
    else $error("rollback popped past its mark");

  // A merge update only happens between two distinct roots.
  a_merge_roots: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MW1) |-> (ra_r != rb_r))
    else $error("merge update on a single root");

  // The table is never written while a root search relies on its read data.
  a_walk_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FA || state_r == ST_FB) |-> (!tbl_wr.par_we && !tbl_wr.size_we))
    else $error("table written during a root search");

endmodule

/* tb/rollback_union_find_unit_tb.sv */
module rollback_union_find_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam ruf_pkg::opcode_t OP_SPARE     = 2'd3;
  localparam int               CYCLE_LIMIT  = 400000;
  localparam int               DRAIN_CYCLES = 40;
  localparam int               RESET_CYCLES = 9;
  localparam int               DIR_ROWS     = 20;

  typedef struct packed {
    ruf_pkg::node_t    root_a;
    ruf_pkg::size_t    size_a;
    ruf_pkg::node_t    root_b;
    ruf_pkg::size_t    size_b;
    logic              merged;
    ruf_pkg::log_cnt_t log_len;
  } uf_result_t;

  typedef struct {
    ruf_pkg::opcode_t op;
    ruf_pkg::node_t   a;
    ruf_pkg::node_t   b;
    logic [10:0]      mark;
    bit               typed;
    uf_result_t       res;
  } dir_row_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_PATTERN, RX_SPARSE} rx_mode_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  ruf_in_if  in_ch();
  ruf_out_if out_ch();

  rollback_union_find_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #6 clk = ~clk;

  ruf_pkg::node_t     link_tbl [ruf_pkg::NODES];
  ruf_pkg::size_t     size_tbl [ruf_pkg::NODES];
  ruf_pkg::undo_rec_t journal  [$];
  uf_result_t         pending_q[$];
  dir_row_t           dir_tbl  [DIR_ROWS];

  int       errors     = 0;
  int       cyc        = 0;
  int       burst_left = 0;
  rx_mode_t rx_mode    = RX_OPEN;

  function automatic ruf_pkg::node_t root_of(ruf_pkg::node_t start);
    ruf_pkg::node_t x;
    int             steps;
    x = start;
    steps = 0;
    while (x != link_tbl[x] && steps < ruf_pkg::NODES) begin
      x = link_tbl[link_tbl[x]];
      steps++;
    end
    return x;
  endfunction

  function automatic uf_result_t union_step(ruf_pkg::opcode_t op, ruf_pkg::node_t a,
                                            ruf_pkg::node_t b, logic [10:0] mark);
    ruf_pkg::node_t     x;
    ruf_pkg::node_t     y;
    ruf_pkg::node_t     t;
    ruf_pkg::undo_rec_t rec;
    uf_result_t         r;
    r = '0;
    if (op == ruf_pkg::OP_MERGE) begin
      x = root_of(a);
      y = root_of(b);
      if (x != y) begin
        if (size_tbl[x] > size_tbl[y]) begin
          t = x;
          x = y;
          y = t;
        end
        if (journal.size() < ruf_pkg::LOG_DEPTH)
          journal.insert(journal.size(), ruf_pkg::undo_rec_t'{is_size: 1'b0, index: x,
                         value: ruf_pkg::size_t'(link_tbl[x])});
        link_tbl[x] = y;
        if (journal.size() < ruf_pkg::LOG_DEPTH)
          journal.insert(journal.size(), ruf_pkg::undo_rec_t'{is_size: 1'b1, index: y,
                         value: size_tbl[y]});
        size_tbl[y] = size_tbl[y] + size_tbl[x];
        r.merged = 1'b1;
      end
    end else if (op == ruf_pkg::OP_ROLLBACK) begin
      while (journal.size() > int'(mark)) begin
        rec = journal[$];
        journal.delete(journal.size() - 1);
        if (rec.is_size)
          size_tbl[rec.index] = rec.value;
        else
          link_tbl[rec.index] = ruf_pkg::node_t'(rec.value);
      end
    end
    r.root_a  = root_of(a);
    r.size_a  = size_tbl[r.root_a];
    r.root_b  = root_of(b);
    r.size_b  = size_tbl[r.root_b];
    r.log_len = ruf_pkg::log_cnt_t'(journal.size());
    return r;
  endfunction

  function automatic ruf_pkg::node_t pick_node();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4)
      return ruf_pkg::node_t'($urandom_range(0, 15));
    else if (r < 7)
      return ruf_pkg::node_t'($urandom_range(0, 127));
    return ruf_pkg::node_t'($urandom);
  endfunction

  task automatic issue(ruf_pkg::opcode_t op, ruf_pkg::node_t a, ruf_pkg::node_t b,
                       logic [10:0] mark, bit typed, uf_result_t typed_res);
    int         gap;
    uf_result_t pred;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      for (int i = 0; i < gap; i++) begin
        in_ch.valid         <= 1'b0;
        in_ch.opcode        <= ruf_pkg::opcode_t'($urandom);
        in_ch.node_a        <= ruf_pkg::node_t'($urandom);
        in_ch.node_b        <= ruf_pkg::node_t'($urandom);
        in_ch.rollback_mark <= 11'($urandom);
        @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_ch.valid         <= 1'b1;
    in_ch.opcode        <= op;
    in_ch.node_a        <= a;
    in_ch.node_b        <= b;
    in_ch.rollback_mark <= mark;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    burst_left--;
    pred = union_step(op, a, b, mark);
    pending_q.insert(pending_q.size(), typed ? typed_res : pred);
  endtask

  task automatic random_phase(int count);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 55)
        issue(ruf_pkg::OP_MERGE, pick_node(), pick_node(), 11'($urandom), 1'b0, '0);
      else if (r < 70)
        issue(ruf_pkg::OP_QUERY, pick_node(), pick_node(), 11'($urandom), 1'b0, '0);
      else if (r < 88)
        issue(ruf_pkg::OP_ROLLBACK, pick_node(), pick_node(),
              ($urandom_range(0, 4) == 0) ? 11'($urandom)
                                          : 11'($urandom_range(0, journal.size())),
              1'b0, '0);
      else
        issue(OP_SPARE, pick_node(), pick_node(), 11'($urandom), 1'b0, '0);
    end
  endtask

  // Pairwise merges of equal-sized sets build trees of the greatest depth the
  // sizing rule allows, and finally one set holding every node.
  task automatic build_full_forest();
    int step;
    issue(ruf_pkg::OP_ROLLBACK, pick_node(), pick_node(), 11'd0, 1'b0, '0);
    for (int k = 0; k < ruf_pkg::NW; k++) begin
      step = 1 << k;
      for (int j = 0; j < ruf_pkg::NODES; j += 2 * step) begin
        if ($urandom_range(0, 1) == 0)
          issue(ruf_pkg::OP_MERGE, ruf_pkg::node_t'(j), ruf_pkg::node_t'(j + step),
                11'($urandom), 1'b0, '0);
        else
          issue(ruf_pkg::OP_MERGE, ruf_pkg::node_t'(j + step), ruf_pkg::node_t'(j),
                11'($urandom), 1'b0, '0);
        if ($urandom_range(0, 9) == 0)
          issue(ruf_pkg::OP_QUERY, pick_node(), pick_node(), 11'($urandom), 1'b0, '0);
      end
    end
    issue(ruf_pkg::OP_QUERY, ruf_pkg::node_t'(0), ruf_pkg::node_t'(ruf_pkg::NODES - 1),
          11'($urandom), 1'b0, '0);
    issue(ruf_pkg::OP_ROLLBACK, pick_node(), pick_node(), 11'(ruf_pkg::LOG_DEPTH),
          1'b0, '0);
    issue(ruf_pkg::OP_ROLLBACK, pick_node(), pick_node(),
          11'($urandom_range(0, ruf_pkg::LOG_DEPTH)), 1'b0, '0);
  endtask

  always @(posedge clk) begin
    cyc++;
    if (cyc >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $realtime, pending_q.size());
      $display("== FAIL ==");
      $finish;
    end else begin
      if (cyc % 300 == 0)
        rx_mode = rx_mode_t'($urandom_range(0, 3));
      case (rx_mode)
        RX_OPEN:    out_ch.ready <= 1'b1;
        RX_COIN:    out_ch.ready <= ($urandom_range(0, 3) != 0);
        RX_PATTERN: out_ch.ready <= (cyc % 7) < 4;
        default:    out_ch.ready <= ($urandom_range(0, 2) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    uf_result_t got;
    uf_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.root_a, out_ch.set_size_a, out_ch.root_b, out_ch.set_size_b,
              out_ch.merged, out_ch.log_length};
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result ra=%0d sa=%0d rb=%0d sb=%0d m=%0d len=%0d",
                 $realtime, got.root_a, got.size_a, got.root_b, got.size_b,
                 got.merged, got.log_len);
      end else begin
        want = pending_q.pop_front();
        if (got !== want) begin
          errors++;
          $display({"%0t: mismatch expected ra=%0d sa=%0d rb=%0d sb=%0d m=%0d len=%0d",
                    " actual ra=%0d sa=%0d rb=%0d sb=%0d m=%0d len=%0d"},
                   $realtime, want.root_a, want.size_a, want.root_b, want.size_b,
                   want.merged, want.log_len, got.root_a, got.size_a, got.root_b,
                   got.size_b, got.merged, got.log_len);
        end
      end
    end
  end

  initial begin
    in_ch.valid         = 1'b0;
    in_ch.opcode        = ruf_pkg::OP_QUERY;
    in_ch.node_a        = '0;
    in_ch.node_b        = '0;
    in_ch.rollback_mark = '0;
    out_ch.ready        = 1'b0;
    for (int i = 0; i < ruf_pkg::NODES; i++) begin
      link_tbl[i] = ruf_pkg::node_t'(i);
      size_tbl[i] = ruf_pkg::size_t'(1);
    end

    dir_tbl[0]  = '{ruf_pkg::OP_QUERY,    10'd0,    10'd1023, 11'd0,    1'b1,
                    '{10'd0,    11'd1, 10'd1023, 11'd1, 1'b0, 11'd0}};
    dir_tbl[1]  = '{ruf_pkg::OP_MERGE,    10'd0,    10'd1023, 11'd2047, 1'b1,
                    '{10'd1023, 11'd2, 10'd1023, 11'd2, 1'b1, 11'd2}};
    dir_tbl[2]  = '{ruf_pkg::OP_MERGE,    10'd1023, 10'd0,    11'd0,    1'b1,
                    '{10'd1023, 11'd2, 10'd1023, 11'd2, 1'b0, 11'd2}};
    dir_tbl[3]  = '{ruf_pkg::OP_ROLLBACK, 10'd0,    10'd1023, 11'd2047, 1'b1,
                    '{10'd1023, 11'd2, 10'd1023, 11'd2, 1'b0, 11'd2}};
    dir_tbl[4]  = '{ruf_pkg::OP_ROLLBACK, 10'd0,    10'd1023, 11'd2,    1'b1,
                    '{10'd1023, 11'd2, 10'd1023, 11'd2, 1'b0, 11'd2}};
    dir_tbl[5]  = '{ruf_pkg::OP_ROLLBACK, 10'd0,    10'd1023, 11'd0,    1'b1,
                    '{10'd0,    11'd1, 10'd1023, 11'd1, 1'b0, 11'd0}};
    dir_tbl[6]  = '{OP_SPARE,             10'd5,    10'd5,    11'd0,    1'b1,
                    '{10'd5,    11'd1, 10'd5,    11'd1, 1'b0, 11'd0}};
    dir_tbl[7]  = '{ruf_pkg::OP_MERGE,    10'd5,    10'd5,    11'd1365, 1'b1,
                    '{10'd5,    11'd1, 10'd5,    11'd1, 1'b0, 11'd0}};
    dir_tbl[8]  = '{ruf_pkg::OP_ROLLBACK, 10'd1023, 10'd0,    11'd0,    1'b1,
                    '{10'd1023, 11'd1, 10'd0,    11'd1, 1'b0, 11'd0}};
    dir_tbl[9]  = '{ruf_pkg::OP_MERGE,    10'd1,    10'd2,    11'd682,  1'b0, '0};
    dir_tbl[10] = '{ruf_pkg::OP_MERGE,    10'd3,    10'd4,    11'd0,    1'b0, '0};
    dir_tbl[11] = '{ruf_pkg::OP_MERGE,    10'd1,    10'd3,    11'd0,    1'b0, '0};
    dir_tbl[12] = '{ruf_pkg::OP_MERGE,    10'd5,    10'd1,    11'd0,    1'b0, '0};
    dir_tbl[13] = '{ruf_pkg::OP_QUERY,    10'd2,    10'd5,    11'd0,    1'b0, '0};
    dir_tbl[14] = '{ruf_pkg::OP_MERGE,    10'd1022, 10'd1021, 11'd0,    1'b0, '0};
    dir_tbl[15] = '{ruf_pkg::OP_ROLLBACK, 10'd1022, 10'd1021, 11'd9,    1'b0, '0};
    dir_tbl[16] = '{ruf_pkg::OP_QUERY,    10'd1022, 10'd1021, 11'd0,    1'b0, '0};
    dir_tbl[17] = '{ruf_pkg::OP_ROLLBACK, 10'd1,    10'd4,    11'd3,    1'b0, '0};
    dir_tbl[18] = '{OP_SPARE,             10'd1,    10'd4,    11'd2047, 1'b0, '0};
    dir_tbl[19] = '{ruf_pkg::OP_ROLLBACK, 10'd1022, 10'd1,    11'd0,    1'b0, '0};

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++)
      issue(dir_tbl[i].op, dir_tbl[i].a, dir_tbl[i].b, dir_tbl[i].mark,
            dir_tbl[i].typed, dir_tbl[i].res);

    random_phase(250);
    build_full_forest();
    random_phase(250);

    in_ch.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
